// ===== rtl/core/fss_pkg.sv =====
// Package for the filtered sample splat core: constants, command and
// register codes, shared types. No dependencies.
package fss_pkg;

    localparam int TABLE_SIDE_DEF = 16;
    localparam int IMAGE_W_DEF    = 256;
    localparam int IMAGE_H_DEF    = 256;

    localparam int COORD_W = 16;
    localparam int VALUE_W = 20;
    localparam int WEIGHT_W = 16;
    localparam int ACC_W   = 48;
    localparam int WSUM_W  = 40;
    localparam int PROD_W  = VALUE_W + WEIGHT_W;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [2:0] REG_CROP_X_START = 3'd0;
    localparam logic [2:0] REG_CROP_X_COUNT = 3'd1;
    localparam logic [2:0] REG_CROP_Y_START = 3'd2;
    localparam logic [2:0] REG_CROP_Y_COUNT = 3'd3;
    localparam logic [2:0] REG_HALF_X       = 3'd4;
    localparam logic [2:0] REG_HALF_Y       = 3'd5;
    localparam logic [2:0] REG_SCALE_X      = 3'd6;
    localparam logic [2:0] REG_SCALE_Y      = 3'd7;

    typedef struct packed {
        logic [7:0]  crop_x_start;
        logic [8:0]  crop_x_count;
        logic [7:0]  crop_y_start;
        logic [8:0]  crop_y_count;
        logic [10:0] half_width_x;
        logic [10:0] half_width_y;
        logic [15:0] table_scale_x;
        logic [15:0] table_scale_y;
    } cfg_t;

endpackage

// ===== rtl/core/fss_cfg.sv =====
// Configuration register file of the splat core.
// Depends on fss_pkg.
module fss_cfg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output fss_pkg::cfg_t     cfg
);
    import fss_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crop_x_start  <= 8'd0;
            cfg_reg.crop_x_count  <= 9'd256;
            cfg_reg.crop_y_start  <= 8'd0;
            cfg_reg.crop_y_count  <= 9'd256;
            cfg_reg.half_width_x  <= 11'd512;
            cfg_reg.half_width_y  <= 11'd512;
            cfg_reg.table_scale_x <= 16'd8192;
            cfg_reg.table_scale_y <= 16'd8192;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CROP_X_START: cfg_reg.crop_x_start  <= cfg_data[7:0];
                REG_CROP_X_COUNT: cfg_reg.crop_x_count  <= cfg_data[8:0];
                REG_CROP_Y_START: cfg_reg.crop_y_start  <= cfg_data[7:0];
                REG_CROP_Y_COUNT: cfg_reg.crop_y_count  <= cfg_data[8:0];
                REG_HALF_X:       cfg_reg.half_width_x  <= cfg_data[10:0];
                REG_HALF_Y:       cfg_reg.half_width_y  <= cfg_data[10:0];
                REG_SCALE_X:      cfg_reg.table_scale_x <= cfg_data;
                REG_SCALE_Y:      cfg_reg.table_scale_y <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== rtl/core/fss_mac.sv =====
// Shared multiply and saturating accumulate unit: a registered signed
// product and a combinational clamped add. Depends on fss_pkg.
module fss_mac
(
    input  logic                              clk,
    input  logic signed [fss_pkg::WEIGHT_W-1:0] weight,
    input  logic signed [fss_pkg::VALUE_W-1:0]  value,
    input  logic signed [fss_pkg::ACC_W-1:0]    acc_in,
    input  logic                              narrow,
    output logic signed [fss_pkg::ACC_W-1:0]    acc_out
);
    import fss_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W:0]    sum;
    logic signed [ACC_W:0]    hi;
    logic signed [ACC_W:0]    lo;

    always_ff @(posedge clk)
    begin
        prod_reg <= weight * value;
    end

    always_comb
    begin
        sum = {acc_in[ACC_W-1], acc_in} + {{(ACC_W+1-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        if (narrow)
        begin
            hi = (ACC_W+1)'((49'sd1 <<< (WSUM_W-1)) - 49'sd1);
            lo = -(49'sd1 <<< (WSUM_W-1));
        end
        else
        begin
            hi = (ACC_W+1)'((49'sd1 <<< (ACC_W-1)) - 49'sd1);
            lo = -(49'sd1 <<< (ACC_W-1));
        end
        if (sum > hi)
            acc_out = hi[ACC_W-1:0];
        else if (sum < lo)
            acc_out = lo[ACC_W-1:0];
        else
            acc_out = sum[ACC_W-1:0];
    end

endmodule

// ===== rtl/core/fss_seq.sv =====
// Sequencer of the splat core: footprint set-up, pixel walk, table and
// store access through the shared MAC. Depends on fss_pkg and fss_mac.
module fss_seq
#(
    parameter int TABLE_SIDE = fss_pkg::TABLE_SIDE_DEF,
    parameter int IMAGE_W    = fss_pkg::IMAGE_W_DEF,
    parameter int IMAGE_H    = fss_pkg::IMAGE_H_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  fss_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic [15:0]           sample_x,
    input  logic [15:0]           sample_y,
    input  logic signed [19:0]    value_x,
    input  logic signed [19:0]    value_y,
    input  logic signed [19:0]    value_z,
    input  logic [7:0]            table_slot,
    input  logic signed [15:0]    table_weight,
    input  logic [7:0]            pixel_col,
    input  logic [7:0]            pixel_row,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [47:0]    sum_x,
    output logic signed [47:0]    sum_y,
    output logic signed [47:0]    sum_z,
    output logic signed [39:0]    sum_weight
);
    import fss_pkg::*;

    localparam int TDEPTH = TABLE_SIDE * TABLE_SIDE;
    localparam int TIW    = $clog2(TDEPTH);
    localparam int TSW    = $clog2(TABLE_SIDE);
    localparam int XW     = $clog2(IMAGE_W);
    localparam int YW     = $clog2(IMAGE_H);
    localparam int AW     = XW + YW;
    localparam int DEPTH  = IMAGE_W * IMAGE_H;
    localparam int PW     = 20;
    localparam int CW     = 14;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SETUP = 4'd2;
    localparam logic [3:0] S_PIX   = 4'd3;
    localparam logic [3:0] S_READ  = 4'd4;
    localparam logic [3:0] S_MX    = 4'd5;
    localparam logic [3:0] S_MY    = 4'd6;
    localparam logic [3:0] S_MZ    = 4'd7;
    localparam logic [3:0] S_MW    = 4'd8;
    localparam logic [3:0] S_WB    = 4'd9;
    localparam logic [3:0] S_RD    = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_TBL   = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic [47:0] mem_x [DEPTH];
    logic [47:0] mem_y [DEPTH];
    logic [47:0] mem_z [DEPTH];
    logic [39:0] mem_w [DEPTH];
    logic [15:0] wtab  [TDEPTH];

    logic [AW:0] clr_reg;
    logic signed [PW-1:0] dx_reg;
    logic signed [PW-1:0] dy_reg;
    logic signed [19:0]   vx_reg;
    logic signed [19:0]   vy_reg;
    logic signed [19:0]   vz_reg;
    logic signed [CW-1:0] x0_reg;
    logic signed [CW-1:0] x1_reg;
    logic signed [CW-1:0] y1_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic [AW-1:0]        addr_reg;
    logic                 rd_oob_reg;
    logic [47:0] rx_reg;
    logic [47:0] ry_reg;
    logic [47:0] rz_reg;
    logic [39:0] rw_reg;
    logic [15:0] w_reg;
    logic [47:0] nx_reg;
    logic [47:0] ny_reg;
    logic [47:0] nz_reg;
    logic [TSW-1:0] ix_reg;
    logic [TSW-1:0] iy_reg;

    logic signed [CW-1:0] sx0;
    logic signed [CW-1:0] sx1;
    logic signed [CW-1:0] sy0;
    logic signed [CW-1:0] sy1;
    logic signed [CW-1:0] cxe;
    logic signed [CW-1:0] cye;
    logic signed [PW-1:0] sdx;
    logic signed [PW-1:0] sdy;
    logic signed [PW-1:0] offx;
    logic signed [PW-1:0] offy;
    logic [PW-1:0]        magx;
    logic [PW-1:0]        magy;
    logic [PW+15:0]       prx;
    logic [PW+15:0]       pry;
    logic [TSW-1:0]       ixc;
    logic [TSW-1:0]       iyc;
    logic [AW-1:0]        paddr;

    logic signed [15:0] mac_w;
    logic signed [19:0] mac_v;
    logic signed [47:0] mac_acc;
    logic               mac_narrow;
    logic signed [47:0] mac_out;

    fss_mac u_mac
    (
        .clk     (clk),
        .weight  (mac_w),
        .value   (mac_v),
        .acc_in  (mac_acc),
        .narrow  (mac_narrow),
        .acc_out (mac_out)
    );

    function automatic logic [TSW-1:0] clamp_idx(input logic [PW+15:0] p);
        logic [PW-1:0] q;
        q = p[PW+15:16];
        if (q > PW'(TABLE_SIDE - 1))
            return TSW'(TABLE_SIDE - 1);
        return q[TSW-1:0];
    endfunction

    always_comb
    begin
        sdx = PW'({4'd0, sample_x}) - PW'(128);
        sdy = PW'({4'd0, sample_y}) - PW'(128);
        sx0 = CW'((sdx - $signed({9'd0, cfg.half_width_x}) + 20'sd255) >>> 8);
        sx1 = CW'((sdx + $signed({9'd0, cfg.half_width_x})) >>> 8);
        sy0 = CW'((sdy - $signed({9'd0, cfg.half_width_y}) + 20'sd255) >>> 8);
        sy1 = CW'((sdy + $signed({9'd0, cfg.half_width_y})) >>> 8);
        cxe = (32'(cfg.crop_x_count) > IMAGE_W) ? CW'(IMAGE_W) : CW'({5'd0, cfg.crop_x_count});
        cye = (32'(cfg.crop_y_count) > IMAGE_H) ? CW'(IMAGE_H) : CW'({5'd0, cfg.crop_y_count});
        cxe = cxe + CW'({6'd0, cfg.crop_x_start}) - CW'(1);
        cye = cye + CW'({6'd0, cfg.crop_y_start}) - CW'(1);
        if (sx0 < $signed({6'd0, cfg.crop_x_start})) sx0 = $signed({6'd0, cfg.crop_x_start});
        if (sx1 > cxe) sx1 = cxe;
        if (sy0 < $signed({6'd0, cfg.crop_y_start})) sy0 = $signed({6'd0, cfg.crop_y_start});
        if (sy1 > cye) sy1 = cye;

        offx = (PW'(x_reg) <<< 8) - dx_reg;
        offy = (PW'(y_reg) <<< 8) - dy_reg;
        magx = offx[PW-1] ? PW'(-offx) : PW'(offx);
        magy = offy[PW-1] ? PW'(-offy) : PW'(offy);
        prx  = (PW+16)'(magx) * (PW+16)'(cfg.table_scale_x);
        pry  = (PW+16)'(magy) * (PW+16)'(cfg.table_scale_y);
        ixc  = clamp_idx(prx);
        iyc  = clamp_idx(pry);
        paddr = {YW'(y_reg - CW'({6'd0, cfg.crop_y_start})),
                 XW'(x_reg - CW'({6'd0, cfg.crop_x_start}))};
    end

    always_comb
    begin
        mac_w      = w_reg;
        mac_v      = vx_reg;
        mac_acc    = rx_reg;
        mac_narrow = 1'b0;
        case (state_reg)
            S_MY: begin mac_v = vy_reg; mac_acc = rx_reg; end
            S_MZ: begin mac_v = vz_reg; mac_acc = ry_reg; end
            S_MW:
            begin
                mac_w   = 16'sd0;
                mac_v   = 20'sd0;
                mac_acc = rz_reg;
            end
            S_WB:
            begin
                mac_w      = 16'sd1;
                mac_v      = 20'sd0;
                mac_acc    = {{8{rw_reg[39]}}, rw_reg} + {{32{w_reg[15]}}, w_reg};
                mac_narrow = 1'b1;
            end
            default: mac_acc = rx_reg;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign sum_x     = rd_oob_reg ? 48'sd0 : rx_reg;
    assign sum_y     = rd_oob_reg ? 48'sd0 : ry_reg;
    assign sum_z     = rd_oob_reg ? 48'sd0 : rz_reg;
    assign sum_weight = rd_oob_reg ? 40'sd0 : rw_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == (AW+1)'(DEPTH - 1)) state_next = S_IDLE;
            S_IDLE:
                if (in_valid)
                begin
                    unique case (cmd)
                        CMD_ADD:  state_next = S_SETUP;
                        CMD_LOAD: state_next = S_IDLE;
                        CMD_READ: state_next = S_RD;
                        default:  state_next = S_IDLE;
                    endcase
                end
            S_SETUP: state_next = (x1_reg < x0_reg || y1_reg < y_reg) ? S_IDLE : S_PIX;
            S_PIX:   state_next = S_TBL;
            S_TBL:   state_next = S_READ;
            S_READ:  state_next = S_MX;
            S_MX:    state_next = S_MY;
            S_MY:    state_next = S_MZ;
            S_MZ:    state_next = S_MW;
            S_MW:    state_next = S_WB;
            S_WB:
                if (x_reg == x1_reg && y_reg == y1_reg) state_next = S_IDLE;
                else state_next = S_PIX;
            S_RD:    state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                dx_reg <= sdx;
                dy_reg <= sdy;
                vx_reg <= value_x;
                vy_reg <= value_y;
                vz_reg <= value_z;
                x0_reg <= sx0;
                x1_reg <= sx1;
                y1_reg <= sy1;
                x_reg  <= sx0;
                y_reg  <= sy0;
                rd_oob_reg <= (32'(pixel_col) >= IMAGE_W) || (32'(pixel_row) >= IMAGE_H);
                addr_reg <= {YW'(pixel_row), XW'(pixel_col)};
            end
            S_PIX:
            begin
                ix_reg   <= ixc;
                iy_reg   <= iyc;
                addr_reg <= paddr;
            end
            S_WB:
            begin
                if (x_reg == x1_reg)
                begin
                    x_reg <= x0_reg;
                    y_reg <= y_reg + CW'(1);
                end
                else
                    x_reg <= x_reg + CW'(1);
            end
            S_MY: nx_reg <= mac_out;
            S_MZ: ny_reg <= mac_out;
            S_MW: nz_reg <= mac_out;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && cmd == CMD_LOAD && 32'(table_slot) < TDEPTH)
            wtab[TIW'(table_slot)] <= table_weight;
        if (state_reg == S_TBL)
            w_reg <= wtab[TIW'({iy_reg, ix_reg})];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_x[AW'(clr_reg)] <= '0;
            mem_y[AW'(clr_reg)] <= '0;
            mem_z[AW'(clr_reg)] <= '0;
            mem_w[AW'(clr_reg)] <= '0;
        end
        else if (state_reg == S_WB)
        begin
            mem_x[addr_reg] <= nx_reg;
            mem_y[addr_reg] <= ny_reg;
            mem_z[addr_reg] <= nz_reg;
            mem_w[addr_reg] <= mac_out[39:0];
        end
        if (state_reg == S_READ || state_reg == S_RD)
        begin
            rx_reg <= mem_x[addr_reg];
            ry_reg <= mem_y[addr_reg];
            rz_reg <= mem_z[addr_reg];
            rw_reg <= mem_w[addr_reg];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sum_x))
        else $error("read item dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WB |-> $past(state_reg) == S_MW)
        else $error("write-back without full multiply pass");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while result pending");

endmodule

// ===== rtl/core/filtered_sample_splat_core.sv =====
// Top level of the filtered sample splat core.
// Depends on fss_pkg, fss_cfg, fss_seq.
//
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | cmd, sample_x/y, value_x/y/z, table_*, pixel_*
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  out     | out_valid / out_ready  | sum_x, sum_y, sum_z, sum_weight
//
// An add takes each covered pixel (up to 256) through S_PIX, S_TBL, S_READ,
// S_MX, S_MY, S_MZ, S_MW and S_WB, the shared multiply-accumulate unit and
// single store port setting the pace. A load is taken in S_IDLE; a read
// passes S_RD and S_OUT. After reset the store is cleared in S_CLEAR; no
// item is taken meanwhile. A stalled result holds the block.
module filtered_sample_splat_core
#(
    parameter int TABLE_SIDE = fss_pkg::TABLE_SIDE_DEF,
    parameter int IMAGE_W    = fss_pkg::IMAGE_W_DEF,
    parameter int IMAGE_H    = fss_pkg::IMAGE_H_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic [15:0]        sample_x,
    input  logic [15:0]        sample_y,
    input  logic signed [19:0] value_x,
    input  logic signed [19:0] value_y,
    input  logic signed [19:0] value_z,
    input  logic [7:0]         table_slot,
    input  logic signed [15:0] table_weight,
    input  logic [7:0]         pixel_col,
    input  logic [7:0]         pixel_row,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [47:0] sum_x,
    output logic signed [47:0] sum_y,
    output logic signed [47:0] sum_z,
    output logic signed [39:0] sum_weight
);
    import fss_pkg::*;

    cfg_t cfg;

    fss_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fss_seq #(
        .TABLE_SIDE (TABLE_SIDE),
        .IMAGE_W    (IMAGE_W),
        .IMAGE_H    (IMAGE_H)
    ) u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .value_x      (value_x),
        .value_y      (value_y),
        .value_z      (value_z),
        .table_slot   (table_slot),
        .table_weight (table_weight),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sum_x        (sum_x),
        .sum_y        (sum_y),
        .sum_z        (sum_z),
        .sum_weight   (sum_weight)
    );

endmodule
